/* hdl/ltsp_pkg.sv */
// Package for the line token status parser: buffer sizing, character codes,
// keyword strings, controller and line phase types.
// No dependencies; imported by the parser core.
package ltsp_pkg;

    localparam int BUF_LEN = 16;
    localparam int IDX_W   = $clog2(BUF_LEN);

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_FIVE = 8'h35;

    localparam int KW_W = 72;
    localparam logic [KW_W-1:0] KW_CONTROL   = KW_W'("control");
    localparam logic [KW_W-1:0] KW_CONNECTED = KW_W'("connected");
    localparam logic [KW_W-1:0] KW_OFFLINE   = KW_W'("offline");
    localparam logic [KW_W-1:0] KW_WIFI      = KW_W'("wifi");
    localparam logic [KW_W-1:0] KW_STARTED   = KW_W'("started");
    localparam int LEN_CONTROL   = 7;
    localparam int LEN_CONNECTED = 9;
    localparam int LEN_OFFLINE   = 7;
    localparam int LEN_WIFI      = 4;
    localparam int LEN_STARTED   = 7;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_PARAM = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TREAD,
        ST_TCHK,
        ST_WREAD,
        ST_WCHK,
        ST_FIN,
        ST_PREAD,
        ST_PLOAD
    } state_t;

    // Candidate keywords still matching the stored token.
    typedef struct packed {
        logic ctl;
        logic conn;
        logic off;
        logic wifi;
        logic start;
    } match_t;

    // Character i of a keyword held right-aligned in a packed string.
    function automatic logic [7:0] kw_char(input logic [KW_W-1:0] s, input int len,
                                           input logic [IDX_W-1:0] i);
        int pos;
        pos = len - 1 - int'(i);
        if (pos >= 0) begin
            return s[8*pos +: 8];
        end
        return 8'h00;
    endfunction

endpackage

/* hdl/ltsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ltsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/line_token_status_parser_core.sv */
// Line token status parser core: byte-wide input, status/control results out.
// Depends on ltsp_pkg and two ltsp_ram instances (token and parameter buffers).
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry one received serial byte per word.
//   m_valid/m_ready carry one result word: the three status flags, the
//   control fields and m_last, which marks the final word caused by a byte.
//   '#' opens a line, '+' switches from token to parameter, CR or LF ends it.
//   Token and parameter characters go into two 16-entry RAMs (15 kept each).
//
// Flow:
//   An ordinary byte's status word is in the output register the next
//   cycle; with m_ready high and the core idle a byte can be taken every
//   cycle. A line end whose token length fits a keyword reads the token
//   RAM back, a read and a compare step per character (TREAD, TCHK),
//   then a read and check of the wifi parameter (WREAD, WCHK) and a FIN
//   step to apply the flags. A control line then streams its parameter
//   out, a read and a load step per character (PREAD, PLOAD). FIN and
//   PLOAD wait while the output register is not free; the input is held
//   off until the core is idle again.
//
// Reset (aresetn low, synchronous): phase waits for '#', counts and flags
// clear, no result is pending. The RAM contents stay undefined; only entries
// written in the current line are read back.
// Stall: while m_ready is low a pending word holds in the output register and
// the core takes no new byte and starts no new word.
module line_token_status_parser_core
    import ltsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_wifi_up,
    output logic       m_link_up,
    output logic       m_module_started,
    output logic       m_control_event,
    output logic       m_param_present,
    output logic [7:0] m_param_char,
    output logic       m_last
);

    localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(BUF_LEN - 1);

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] tok_cnt_reg, tok_cnt_next;
    logic [IDX_W-1:0] par_cnt_reg, par_cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             has_param_reg, has_param_next;
    match_t           match_reg, match_next;
    logic             wifi_reg, wifi_next;
    logic             link_reg, link_next;
    logic             started_reg, started_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_ctl_reg, out_ctl_next;
    logic             out_pres_reg, out_pres_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic             out_wifi_reg, out_wifi_next;
    logic             out_link_reg, out_link_next;
    logic             out_start_reg, out_start_next;

    logic             tok_we, tok_re, par_we, par_re;
    logic [IDX_W-1:0] tok_raddr, par_raddr, tok_waddr, par_waddr;
    logic [7:0]       tok_rdata, par_rdata;

    logic             out_free;
    logic             accept;
    logic             is_eol;
    logic             end_line;
    logic             end_has_param;
    match_t           len_match;
    match_t           cmp_match;
    logic             tok_done;
    logic             par_done;
    logic             wifi_check;
    logic             ctl_stream;

    ltsp_ram #(.WIDTH(8), .DEPTH(BUF_LEN)) u_tok_ram (
        .aclk  (aclk),
        .we    (tok_we),
        .waddr (tok_waddr),
        .wdata (s_rx_byte),
        .re    (tok_re),
        .raddr (tok_raddr),
        .rdata (tok_rdata)
    );

    ltsp_ram #(.WIDTH(8), .DEPTH(BUF_LEN)) u_par_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (s_rx_byte),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    // The output register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_eol   = (s_rx_byte == CH_CR) || (s_rx_byte == CH_LF);

    // Line end: CR/LF in token (not preceded by '+') or in parameter.
    assign end_line = accept && is_eol &&
                      ((phase_reg == PH_TOKEN) || (phase_reg == PH_PARAM));
    assign end_has_param = (phase_reg == PH_PARAM);

    // Keep only keywords whose length equals the token length.
    always_comb begin
        len_match.ctl   = (tok_cnt_reg == IDX_W'(LEN_CONTROL));
        len_match.conn  = (tok_cnt_reg == IDX_W'(LEN_CONNECTED));
        len_match.off   = (tok_cnt_reg == IDX_W'(LEN_OFFLINE));
        len_match.wifi  = (tok_cnt_reg == IDX_W'(LEN_WIFI));
        len_match.start = (tok_cnt_reg == IDX_W'(LEN_STARTED));
    end

    // Drop candidates whose character at idx differs from the token RAM data.
    always_comb begin
        cmp_match.ctl   = match_reg.ctl &&
                          (tok_rdata == kw_char(KW_CONTROL, LEN_CONTROL, idx_reg));
        cmp_match.conn  = match_reg.conn &&
                          (tok_rdata == kw_char(KW_CONNECTED, LEN_CONNECTED, idx_reg));
        cmp_match.off   = match_reg.off &&
                          (tok_rdata == kw_char(KW_OFFLINE, LEN_OFFLINE, idx_reg));
        cmp_match.wifi  = match_reg.wifi &&
                          (tok_rdata == kw_char(KW_WIFI, LEN_WIFI, idx_reg));
        cmp_match.start = match_reg.start &&
                          (tok_rdata == kw_char(KW_STARTED, LEN_STARTED, idx_reg));
    end

    assign tok_done   = (idx_reg == tok_cnt_reg - IDX_W'(1));
    assign par_done   = (idx_reg == par_cnt_reg - IDX_W'(1));
    assign wifi_check = cmp_match.wifi && has_param_reg && (par_cnt_reg != '0);
    assign ctl_stream = match_reg.ctl && has_param_reg && (par_cnt_reg != '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (end_line) begin
                    state_next = (len_match != '0) ? ST_TREAD : ST_FIN;
                end
            end
            ST_TREAD: state_next = ST_TCHK;
            ST_TCHK: begin
                if (!tok_done) begin
                    state_next = ST_TREAD;
                end else if (wifi_check) begin
                    state_next = ST_WREAD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_WREAD: state_next = ST_WCHK;
            ST_WCHK:  state_next = ST_FIN;
            ST_FIN: begin
                if (ctl_stream) begin
                    state_next = ST_PREAD;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREAD: state_next = ST_PLOAD;
            ST_PLOAD: begin
                if (out_free) begin
                    state_next = par_done ? ST_IDLE : ST_PREAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM controls and result loading.
    always_comb begin
        phase_next     = phase_reg;
        tok_cnt_next   = tok_cnt_reg;
        par_cnt_next   = par_cnt_reg;
        idx_next       = idx_reg;
        has_param_next = has_param_reg;
        match_next     = match_reg;
        wifi_next      = wifi_reg;
        link_next      = link_reg;
        started_next   = started_reg;

        tok_we    = 1'b0;
        par_we    = 1'b0;
        tok_re    = 1'b0;
        par_re    = 1'b0;
        tok_waddr = tok_cnt_reg;
        par_waddr = par_cnt_reg;
        tok_raddr = idx_reg;
        par_raddr = idx_reg;

        out_valid_next = out_valid_reg && !m_ready;
        out_ctl_next   = out_ctl_reg;
        out_pres_next  = out_pres_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_wifi_next  = out_wifi_reg;
        out_link_next  = out_link_reg;
        out_start_next = out_start_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (phase_reg)
                        PH_TOKEN: begin
                            if (s_rx_byte == CH_PLUS) begin
                                par_cnt_next = '0;
                                phase_next   = PH_PARAM;
                            end else if (!is_eol && tok_cnt_reg != CNT_MAX) begin
                                tok_we       = 1'b1;
                                tok_cnt_next = tok_cnt_reg + IDX_W'(1);
                            end
                        end
                        PH_PARAM: begin
                            if (!is_eol && par_cnt_reg != CNT_MAX) begin
                                par_we       = 1'b1;
                                par_cnt_next = par_cnt_reg + IDX_W'(1);
                            end
                        end
                        default: begin
                            // Anything but the start mark is dropped while waiting.
                            phase_next = PH_WAIT;
                            if (s_rx_byte == CH_HASH) begin
                                tok_cnt_next = '0;
                                phase_next   = PH_TOKEN;
                            end
                        end
                    endcase
                    if (end_line) begin
                        phase_next     = PH_WAIT;
                        has_param_next = end_has_param;
                        match_next     = len_match;
                        idx_next       = '0;
                    end else begin
                        // Plain status word for this byte.
                        out_valid_next = 1'b1;
                        out_ctl_next   = 1'b0;
                        out_pres_next  = 1'b0;
                        out_char_next  = 8'h00;
                        out_last_next  = 1'b1;
                        out_wifi_next  = wifi_reg;
                        out_link_next  = link_reg;
                        out_start_next = started_reg;
                    end
                end
            end
            ST_TREAD: begin
                tok_re = 1'b1;
            end
            ST_TCHK: begin
                match_next = cmp_match;
                idx_next   = tok_done ? '0 : idx_reg + IDX_W'(1);
            end
            ST_WREAD: begin
                par_re    = 1'b1;
                par_raddr = '0;
            end
            ST_WCHK: begin
                if (par_rdata == CH_FIVE) begin
                    wifi_next = 1'b1;
                end
            end
            ST_FIN: begin
                // Apply flag updates; repeating them while stalled is harmless.
                if (match_reg.conn) begin
                    link_next = 1'b1;
                end
                if (match_reg.off) begin
                    link_next = 1'b0;
                end
                if (match_reg.start) begin
                    started_next = 1'b1;
                end
                if (!ctl_stream && out_free) begin
                    out_valid_next = 1'b1;
                    out_ctl_next   = match_reg.ctl;
                    out_pres_next  = match_reg.ctl && has_param_reg;
                    out_char_next  = 8'h00;
                    out_last_next  = 1'b1;
                    out_wifi_next  = wifi_next;
                    out_link_next  = link_next;
                    out_start_next = started_next;
                end
                idx_next = '0;
            end
            ST_PREAD: begin
                par_re = 1'b1;
            end
            ST_PLOAD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_ctl_next   = 1'b1;
                    out_pres_next  = 1'b1;
                    out_char_next  = par_rdata;
                    out_last_next  = par_done;
                    out_wifi_next  = wifi_reg;
                    out_link_next  = link_reg;
                    out_start_next = started_reg;
                    idx_next       = par_done ? '0 : idx_reg + IDX_W'(1);
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WAIT;
            tok_cnt_reg   <= '0;
            par_cnt_reg   <= '0;
            idx_reg       <= '0;
            has_param_reg <= 1'b0;
            match_reg     <= '0;
            wifi_reg      <= 1'b0;
            link_reg      <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tok_cnt_reg   <= tok_cnt_next;
            par_cnt_reg   <= par_cnt_next;
            idx_reg       <= idx_next;
            has_param_reg <= has_param_next;
            match_reg     <= match_next;
            wifi_reg      <= wifi_next;
            link_reg      <= link_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_ctl_reg   <= out_ctl_next;
        out_pres_reg  <= out_pres_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_wifi_reg  <= out_wifi_next;
        out_link_reg  <= out_link_next;
        out_start_reg <= out_start_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_wifi_up        = out_wifi_reg;
    assign m_link_up        = out_link_reg;
    assign m_module_started = out_start_reg;
    assign m_control_event  = out_ctl_reg;
    assign m_param_present  = out_pres_reg;
    assign m_param_char     = out_char_reg;
    assign m_last           = out_last_reg;

endmodule

/* bench/ltsp_status_checker.sv */
// Status word checker for the line token status parser: tracks the line
// phase, stored token and parameter, and the three flags, and checks each word.
// Depends on ltsp_pkg for BUF_LEN, character codes and phase_t.
module ltsp_status_checker
    import ltsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_wifi_up,
    input  logic       m_link_up,
    input  logic       m_module_started,
    input  logic       m_control_event,
    input  logic       m_param_present,
    input  logic [7:0] m_param_char,
    input  logic       m_last,
    output int         fail_count,
    output int         words_pending
);

    typedef struct packed {
        logic       wifi_up;
        logic       link_up;
        logic       module_started;
        logic       control_event;
        logic       param_present;
        logic [7:0] param_char;
        logic       last;
    } status_word_t;

    status_word_t status_words_due[$];

    phase_t     line_phase;
    logic [7:0] tok_mem [BUF_LEN];
    int         tok_len;
    logic [7:0] par_mem [BUF_LEN];
    int         par_len;
    logic       wifi_seen;
    logic       link_on;
    logic       started_seen;

    function automatic bit token_equals(string kw);
        int i;
        if (tok_len != kw.len()) begin
            return 0;
        end
        for (i = 0; i < tok_len; i++) begin
            if (tok_mem[i] != kw[i]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    // Flags are taken as they stand after the current byte.
    function automatic void push_status(logic ctl, logic pres, logic [7:0] ch, logic fin);
        status_word_t w;
        w.wifi_up        = wifi_seen;
        w.link_up        = link_on;
        w.module_started = started_seen;
        w.control_event  = ctl;
        w.param_present  = pres;
        w.param_char     = ch;
        w.last           = fin;
        status_words_due.push_back(w);
    endfunction

    // Apply the keyword of a finished line; return 1 if it emitted control words.
    function automatic bit close_line(bit has_par);
        int i;
        bit emitted;
        emitted = 0;
        if (token_equals("connected")) begin
            link_on = 1'b1;
        end else if (token_equals("offline")) begin
            link_on = 1'b0;
        end else if (token_equals("wifi")) begin
            if (has_par && par_len > 0 && par_mem[0] == CH_FIVE) begin
                wifi_seen = 1'b1;
            end
        end else if (token_equals("started")) begin
            started_seen = 1'b1;
        end
        if (token_equals("control")) begin
            if (!has_par || par_len == 0) begin
                push_status(1'b1, has_par, 8'h00, 1'b1);
            end else begin
                for (i = 0; i < par_len; i++) begin
                    push_status(1'b1, 1'b1, par_mem[i], i == par_len - 1);
                end
            end
            emitted = 1;
        end
        line_phase = PH_WAIT;
        return emitted;
    endfunction

    function automatic void predict_status(logic [7:0] b);
        bit eol;
        bit emitted;
        eol     = (b == CH_CR) || (b == CH_LF);
        emitted = 0;
        case (line_phase)
            PH_TOKEN: begin
                if (b == CH_PLUS) begin
                    par_len    = 0;
                    line_phase = PH_PARAM;
                end else if (eol) begin
                    emitted = close_line(0);
                end else if (tok_len < BUF_LEN - 1) begin
                    tok_mem[tok_len] = b;
                    tok_len++;
                end
            end
            PH_PARAM: begin
                if (eol) begin
                    emitted = close_line(1);
                end else if (par_len < BUF_LEN - 1) begin
                    par_mem[par_len] = b;
                    par_len++;
                end
            end
            default: begin
                line_phase = PH_WAIT;
                if (b == CH_HASH) begin
                    tok_len    = 0;
                    line_phase = PH_TOKEN;
                end
            end
        endcase
        if (!emitted) begin
            push_status(1'b0, 1'b0, 8'h00, 1'b1);
        end
    endfunction

    always @(posedge aclk) begin
        status_word_t got;
        status_word_t want;
        if (!aresetn) begin
            line_phase   = PH_WAIT;
            tok_len      = 0;
            par_len      = 0;
            wifi_seen    = 1'b0;
            link_on      = 1'b0;
            started_seen = 1'b0;
            fail_count   = 0;
            status_words_due.delete();
            words_pending = 0;
        end else begin
            // Retire the output word first: it can never belong to a byte taken this edge.
            if (m_valid && m_ready) begin
                got = {m_wifi_up, m_link_up, m_module_started, m_control_event,
                       m_param_present, m_param_char, m_last};
                if (status_words_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected word wifi=%b link=%b start=%b ctl=%b pres=%b ch=%02h last=%b",
                                 $time, got.wifi_up, got.link_up, got.module_started,
                                 got.control_event, got.param_present, got.param_char, got.last);
                    end
                end else begin
                    want = status_words_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch expected wifi=%b link=%b start=%b ctl=%b pres=%b ch=%02h last=%b",
                                     $time, want.wifi_up, want.link_up, want.module_started,
                                     want.control_event, want.param_present, want.param_char,
                                     want.last);
                            $display("%0t:          actual   wifi=%b link=%b start=%b ctl=%b pres=%b ch=%02h last=%b",
                                     $time, got.wifi_up, got.link_up, got.module_started,
                                     got.control_event, got.param_present, got.param_char,
                                     got.last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_status(s_rx_byte);
            end
            words_pending = status_words_due.size();
        end
    end

endmodule

/* bench/tb_line_token_status_parser_core.sv */
// Testbench top for line_token_status_parser_core: clock, reset, byte stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on ltsp_pkg, the parser core and ltsp_status_checker.
module tb_line_token_status_parser_core
    import ltsp_pkg::*;
();

    localparam int MAX_GAP           = 11;
    localparam int HOLD_CYCLES       = 300;   // long receiver hold-off
    localparam int STALL_LIMIT       = 4000;  // idle cycles before giving up
    localparam int TAIL_CYCLES       = 60;    // covers the worst control line
    localparam int RANDOM_LINE_WORDS = 150;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_wifi_up;
    logic       m_link_up;
    logic       m_module_started;
    logic       m_control_event;
    logic       m_param_present;
    logic [7:0] m_param_char;
    logic       m_last;

    int fail_count;
    int words_pending;

    bit         idle_en  = 1'b1;  // both sides insert random gaps when set
    bit         hold_req = 1'b0;  // ask the receiver for one long hold-off
    int         stall_cycles = 0;
    int         line_words   = 0;
    logic [7:0] line_q[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_token_status_parser_core dut (.*);

    ltsp_status_checker u_checker (.*);

    // Watchdog: count edges at which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: draw a wait before each word, then hold ready until a word moves.
    // A pending hold request turns into one long stretch with ready low.
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Offer one byte after a random gap; return at the edge that takes it.
    // Valid stays high on return so a back-to-back byte needs no low pulse.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold the sender until every expected word has come back.
    task automatic wait_all_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_pending != 0) @(negedge aclk);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_q.size(); i++) begin
            send_byte(line_q[i]);
        end
        line_words += line_q.size();
        line_q.delete();
    endtask

    function automatic void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            line_q.push_back(s[i]);
        end
    endfunction

    function automatic string keyword(int k);
        case (k)
            0:       return "control";
            1:       return "connected";
            2:       return "offline";
            3:       return "wifi";
            default: return "started";
        endcase
    endfunction

    // Any byte except a line end, with the two marks drawn more often.
    function automatic logic [7:0] rand_char();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return CH_HASH;
        end
        if (pick == 1) begin
            return CH_PLUS;
        end
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // Bytes between lines: anything but '#', line ends included.
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_HASH);
            send_byte(b);
        end
    endtask

    // Mostly well-formed keyword lines with random parameters; the rest are
    // near-miss keywords, random or overlong tokens, and lines left unterminated.
    task automatic build_random_line();
        int    n;
        int    i;
        int    pos;
        string kw;
        line_q.push_back(CH_HASH);
        if ($urandom_range(0, 9) < 7) begin
            kw = keyword($urandom_range(0, 4));
            add_text(kw);
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) != 0) begin
                    pos = $urandom_range(1, kw.len());
                    line_q[pos] = line_q[pos] ^ (8'h01 << $urandom_range(0, 4));
                end else begin
                    line_q.push_back(rand_char());
                end
            end
        end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
            repeat (n) line_q.push_back(rand_char());
        end
        if ($urandom_range(0, 9) < 6) begin
            line_q.push_back(CH_PLUS);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 19) : $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
                line_q.push_back((i == 0 && $urandom_range(0, 1) != 0) ? CH_FIVE : rand_char());
            end
        end
        if ($urandom_range(0, 11) != 0) begin
            line_q.push_back(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        end
    endtask

    // Fill the core while the receiver holds off: a full-length control line
    // (extra characters dropped) followed by more bytes that must stall.
    task automatic fill_under_hold();
        int i;
        wait_all_results();
        hold_req = 1'b1;
        add_text("#control+");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        line_q.push_back(CH_HASH);
        line_q.push_back(CH_PLUS);
        for (i = 0; i < 13; i++) begin
            line_q.push_back(rand_char());
        end
        line_q.push_back(CH_LF);
        add_text("#started");
        line_q.push_back(CH_CR);
        send_line();
        wait_all_results();
    endtask

    initial begin
        bit pressed;
        pressed = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme bytes while waiting, a lone line end, then control
        // without and with an empty parameter, and wifi without and with an
        // empty parameter.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_LF);
        add_text("#control");
        line_q.push_back(CH_LF);
        send_line();
        add_text("#control+");
        line_q.push_back(CH_CR);
        send_line();
        add_text("#wifi");
        line_q.push_back(CH_CR);
        send_line();
        add_text("#wifi+");
        line_q.push_back(CH_LF);
        send_line();
        wait_all_results();

        // Random lines; roughly one in four runs with no gaps on either side.
        while (line_words < RANDOM_LINE_WORDS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end
            build_random_line();
            send_line();
            if (!pressed && line_words >= RANDOM_LINE_WORDS / 2) begin
                idle_en = 1'b1;
                fill_under_hold();
                pressed = 1;
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_all_results();
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/ltsp_pkg.sv
hdl/ltsp_ram.sv
hdl/line_token_status_parser_core.sv
bench/ltsp_status_checker.sv
bench/tb_line_token_status_parser_core.sv
